@@ rtl/bts_pkg.sv @@
// bts_pkg: shared widths, register codes, status struct and the divide-by-ten digit step
// for the blob target selector. No dependencies.

package bts_pkg;

	// field widths
	localparam int COORD_W  = 12;   // blob_left, blob_top
	localparam int SIZE_W   = 13;   // blob_width, blob_height, frame size, target
	localparam int AREA_W   = 25;   // blob_area and kept maxima
	localparam int ANCH_X_W = 14;   // red anchor column can reach left + width
	localparam int ANCH_Y_W = 13;   // top + height/2

	// distance unit
	localparam int DX_W       = ANCH_X_W;
	localparam int DY_W       = ANCH_Y_W;
	localparam int SQ_W       = 30;           // dx*dx + dy*dy, padded to an even width
	localparam int ROOT_W     = SQ_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int MUL_STEPS  = DX_W;         // one multiplier bit per cycle
	localparam int ROOT_STEPS = ROOT_W;       // one root bit per cycle
	localparam int CNT_W      = 5;

	// area ratio test: (a / 10) * 7, one dividend bit per cycle
	localparam int DIV_STEPS = AREA_W;
	localparam int DCNT_W    = 5;
	localparam int DivBase   = 10;
	localparam int Ratio     = 7;
	localparam int DREM_W    = 4;

	// configuration port
	localparam int DATA_W     = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_IDX_LSB = 2;
	localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;
	localparam logic [SIZE_W-1:0] FW_RESET = 13'd640;
	localparam logic [SIZE_W-1:0] FH_RESET = 13'd480;

	typedef struct packed {
		logic              busy;
		logic [ROOT_W-1:0] root;
	} dist_stat_t;

	// one restoring step of a divide by ten: {quotient bit, next remainder}
	function automatic logic [DREM_W:0] div10_step(input logic [DREM_W-1:0] rem,
			input logic b);
		logic [DREM_W:0] r;
		r = {rem, b};
		if (r >= (DREM_W+1)'(DivBase)) begin
			div10_step = {1'b1, DREM_W'(r - (DREM_W+1)'(DivBase))};
		end else begin
			div10_step = {1'b0, r[DREM_W-1:0]};
		end
	endfunction

endpackage

@@ rtl/bts_in_if.sv @@
// bts_in_if: input channel of the blob target selector, one blob record per word.
// Depends on bts_pkg for field widths.

interface bts_in_if;
	logic                             valid;
	logic                             ready;
	logic                             has_blob;
	logic [bts_pkg::COORD_W-1:0]      blob_left;
	logic [bts_pkg::COORD_W-1:0]      blob_top;
	logic [bts_pkg::SIZE_W-1:0]       blob_width;
	logic [bts_pkg::SIZE_W-1:0]       blob_height;
	logic [bts_pkg::AREA_W-1:0]       blob_area;
	logic                             is_yellow;
	logic                             is_last;

	modport source(output valid, has_blob, blob_left, blob_top, blob_width, blob_height,
		blob_area, is_yellow, is_last, input ready);
	modport sink(input valid, has_blob, blob_left, blob_top, blob_width, blob_height,
		blob_area, is_yellow, is_last, output ready);
endinterface

@@ rtl/bts_out_if.sv @@
// bts_out_if: output channel of the blob target selector, one target point per word.
// Depends on bts_pkg for field widths.

interface bts_out_if;
	logic                        valid;
	logic                        ready;
	logic [bts_pkg::SIZE_W-1:0]  target_x;
	logic [bts_pkg::SIZE_W-1:0]  target_y;

	modport source(output valid, target_x, target_y, input ready);
	modport sink(input valid, target_x, target_y, output ready);
endinterface

@@ rtl/bts_dist.sv @@
// bts_dist: floor(sqrt(dx*dx + dy*dy)), bit-serial square (one multiplier bit a cycle)
// then restoring square root (one root bit a cycle). Depends on bts_pkg.

module bts_dist (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bts_pkg::DX_W-1:0]   dx,
	input  logic [bts_pkg::DY_W-1:0]   dy,
	output bts_pkg::dist_stat_t        stat
);
	localparam int SQ_W   = bts_pkg::SQ_W;
	localparam int REM_W  = bts_pkg::REM_W;
	localparam int ROOT_W = bts_pkg::ROOT_W;
	localparam int CNT_W  = bts_pkg::CNT_W;
	localparam logic [CNT_W-1:0] LAST_STEP =
		CNT_W'(bts_pkg::MUL_STEPS + bts_pkg::ROOT_STEPS - 1);
	localparam logic [CNT_W-1:0] MUL_END = CNT_W'(bts_pkg::MUL_STEPS);

	logic                     busy_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [bts_pkg::DX_W-1:0] xm_q;
	logic [bts_pkg::DY_W-1:0] ym_q;
	logic [SQ_W-1:0]          xs_q, ys_q, acc_q;
	logic [REM_W-1:0]         rem_q;
	logic [ROOT_W-1:0]        root_q;

	logic [SQ_W-1:0]          pp;
	logic [REM_W+1:0]         rem_sh, trial, rem_nx;
	logic                     ge;

	always_comb begin
		pp     = (xm_q[0] ? xs_q : '0) + (ym_q[0] ? ys_q : '0);
		rem_sh = {rem_q, acc_q[SQ_W-1 -: 2]};
		trial  = (REM_W+2)'({root_q, 2'b01});
		ge     = rem_sh >= trial;
		rem_nx = ge ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			xm_q   <= dx;
			ym_q   <= dy;
			xs_q   <= SQ_W'(dx);
			ys_q   <= SQ_W'(dy);
			acc_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < MUL_END) begin
				// shift-add square of both legs into one sum
				acc_q <= acc_q + pp;
				xm_q  <= xm_q >> 1;
				ym_q  <= ym_q >> 1;
				xs_q  <= xs_q << 1;
				ys_q  <= ys_q << 1;
			end else begin
				// two radicand bits per root bit, MSB first
				acc_q  <= acc_q << 2;
				rem_q  <= REM_W'(rem_nx);
				root_q <= {root_q[ROOT_W-2:0], ge};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.root = root_q;

endmodule

@@ rtl/blob_target_selector.sv @@
// blob_target_selector: steering target from per-frame blob records (yellow/red anchors).
// Blob word: ready is low from acceptance through calc and update (the bit-serial distance
// units set the calc length; the two 25-step divide-by-ten chains run alongside). Empty word:
// ready stays high unless last. Last word: result register loads in the finish state once any
// earlier result is taken; a pending result does not stall further input until the next last
// word. arst_n clears all control, anchors and maxima; sets frame_width 640, frame_height 480.

module blob_target_selector (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB-style configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bts_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [bts_pkg::DATA_W-1:0]         pwdata,
	output logic [bts_pkg::DATA_W-1:0]         prdata,
	output logic                               pready,
	// channels
	bts_in_if.sink                             blob_in,
	bts_out_if.source                          target_out
);
	localparam int SIZE_W   = bts_pkg::SIZE_W;
	localparam int AREA_W   = bts_pkg::AREA_W;
	localparam int AX_W     = bts_pkg::ANCH_X_W;
	localparam int AY_W     = bts_pkg::ANCH_Y_W;
	localparam int COORD_W  = bts_pkg::COORD_W;
	localparam int DREM_W   = bts_pkg::DREM_W;
	localparam int DCNT_W   = bts_pkg::DCNT_W;
	localparam logic [DCNT_W-1:0] DIV_END = DCNT_W'(bts_pkg::DIV_STEPS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [SIZE_W-1:0] fw_q, fh_q;
	logic              cfg_wr;
	logic [0:0]        cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[bts_pkg::CFG_IDX_LSB];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= bts_pkg::FW_RESET;
			fh_q <= bts_pkg::FH_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				bts_pkg::REG_FRAME_WIDTH:  fw_q <= pwdata[SIZE_W-1:0];
				bts_pkg::REG_FRAME_HEIGHT: fh_q <= pwdata[SIZE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			bts_pkg::REG_FRAME_WIDTH:  prdata = bts_pkg::DATA_W'(fw_q);
			bts_pkg::REG_FRAME_HEIGHT: prdata = bts_pkg::DATA_W'(fh_q);
		endcase
	end

	// ---------------------------------------------------------------
	// per-frame state and control
	// ---------------------------------------------------------------
	state_t             state_q, state_d;
	logic [AX_W-1:0]    red_x_q;
	logic [AY_W-1:0]    red_y_q;
	logic [AREA_W-1:0]  red_max_q;
	logic [COORD_W-1:0] yellow_x_q;
	logic [AY_W-1:0]    yellow_y_q;
	logic [AREA_W-1:0]  yellow_max_q;
	logic               out_valid_q;
	logic [SIZE_W-1:0]  out_x_q, out_y_q;
	logic [DCNT_W-1:0]  dcnt_q;

	// captured blob word and divider shift registers (payload, no reset)
	logic [AX_W-1:0]    cand_x_q;
	logic [AY_W-1:0]    cand_y_q;
	logic [AREA_W-1:0]  cand_area_q;
	logic               cand_yellow_q;
	logic               cand_last_q;
	logic [AREA_W-1:0]  qa_q, qm_q;      // dividend shifts out, quotient shifts in
	logic [DREM_W-1:0]  ra_q, rm_q;

	logic               in_acc, dist_start, out_load;

	assign blob_in.ready = (state_q == ST_IDLE);
	assign in_acc        = blob_in.valid && blob_in.ready;
	assign dist_start    = in_acc && blob_in.has_blob;
	assign out_load      = (state_q == ST_FIN) && (!out_valid_q || target_out.ready);

	// anchor of the incoming blob and the one it competes with
	logic [AX_W-1:0]    in_x, old_x, base_x;
	logic [AY_W-1:0]    in_y, old_y;
	logic [AREA_W-1:0]  old_max;
	logic [AX_W-1:0]    dx_new, dx_old;
	logic [AY_W-1:0]    dy_new, dy_old;

	always_comb begin
		in_y = AY_W'(blob_in.blob_top) + AY_W'(blob_in.blob_height >> 1);
		if (blob_in.is_yellow) begin
			in_x    = AX_W'(blob_in.blob_left);
			old_x   = AX_W'(yellow_x_q);
			old_y   = yellow_y_q;
			old_max = yellow_max_q;
		end else begin
			in_x    = AX_W'(blob_in.blob_left) + AX_W'(blob_in.blob_width);
			old_x   = red_x_q;
			old_y   = red_y_q;
			old_max = red_max_q;
		end
		// base point: (frame_width/2, frame_height)
		base_x = AX_W'(fw_q >> 1);
		dx_new = (in_x > base_x) ? in_x - base_x : base_x - in_x;
		dx_old = (old_x > base_x) ? old_x - base_x : base_x - old_x;
		dy_new = (in_y > fh_q) ? in_y - fh_q : fh_q - in_y;
		dy_old = (old_y > fh_q) ? old_y - fh_q : fh_q - old_y;
	end

	bts_pkg::dist_stat_t d_new, d_old;

	bts_dist u_dist_new (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.dx     (dx_new),
		.dy     (dy_new),
		.stat   (d_new)
	);

	bts_dist u_dist_old (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.dx     (dx_old),
		.dy     (dy_old),
		.stat   (d_old)
	);

	// divide-by-ten steps for area and kept maximum
	logic [DREM_W:0] sa, sm;
	assign sa = bts_pkg::div10_step(ra_q, qa_q[AREA_W-1]);
	assign sm = bts_pkg::div10_step(rm_q, qm_q[AREA_W-1]);

	always_ff @(posedge clk) begin
		if (dist_start) begin
			cand_x_q      <= in_x;
			cand_y_q      <= in_y;
			cand_area_q   <= blob_in.blob_area;
			cand_yellow_q <= blob_in.is_yellow;
			qa_q          <= blob_in.blob_area;
			qm_q          <= old_max;
			ra_q          <= '0;
			rm_q          <= '0;
		end else if (state_q == ST_CALC && dcnt_q != DIV_END) begin
			qa_q <= {qa_q[AREA_W-2:0], sa[DREM_W]};
			qm_q <= {qm_q[AREA_W-2:0], sm[DREM_W]};
			ra_q <= sa[DREM_W-1:0];
			rm_q <= sm[DREM_W-1:0];
		end
		if (in_acc) begin
			cand_last_q <= blob_in.is_last;
		end
	end

	// update decision: take the anchor, raise the maximum, or drop the blob
	logic [AREA_W-1:0] sel_max, area7, max7, new_max;
	logic              take;

	always_comb begin
		sel_max = cand_yellow_q ? yellow_max_q : red_max_q;
		area7   = AREA_W'(qa_q * AREA_W'(bts_pkg::Ratio));
		max7    = AREA_W'(qm_q * AREA_W'(bts_pkg::Ratio));
		new_max = sel_max;
		take    = 1'b0;
		priority if (sel_max < area7) begin
			// clearly larger blob: replaces the anchor outright
			new_max = cand_area_q;
			take    = 1'b1;
		end else if (cand_area_q > sel_max) begin
			new_max = cand_area_q;
			take    = d_old.root > d_new.root;
		end else if (cand_area_q < max7) begin
			take = 1'b0;   // too small against the kept maximum
		end else begin
			take = d_old.root > d_new.root;
		end
	end

	// result with fallbacks for missing classes
	logic [AX_W:0]     sum_x;
	logic [AY_W:0]     sum_y;
	logic [AX_W-1:0]   mid_x;
	logic [AY_W-1:0]   mid_y;
	logic [SIZE_W-1:0] tx, ty;

	always_comb begin
		sum_x = (AX_W+1)'(red_x_q) + (AX_W+1)'(yellow_x_q);
		sum_y = (AY_W+1)'(red_y_q) + (AY_W+1)'(yellow_y_q);
		mid_x = sum_x[AX_W:1];
		mid_y = sum_y[AY_W:1];
		priority if (mid_x == '0 && mid_y == '0) begin
			tx = fw_q >> 1;
			ty = fh_q >> 1;
		end else if (red_x_q == '0 && red_y_q == '0) begin
			tx = '0;
			ty = yellow_y_q;
		end else if (yellow_x_q == '0 && yellow_y_q == '0) begin
			tx = fw_q;
			ty = red_y_q;
		end else begin
			tx = mid_x[SIZE_W-1:0];
			ty = mid_y;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (blob_in.has_blob) begin
						state_d = ST_CALC;
					end else if (blob_in.is_last) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_CALC: begin
				if (dcnt_q == DIV_END && !d_new.busy && !d_old.busy) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				state_d = cand_last_q ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dcnt_q       <= '0;
			out_valid_q  <= 1'b0;
			red_x_q      <= '0;
			red_y_q      <= '0;
			red_max_q    <= '0;
			yellow_x_q   <= '0;
			yellow_y_q   <= '0;
			yellow_max_q <= '0;
		end else begin
			state_q <= state_d;

			if (dist_start) begin
				dcnt_q <= '0;
			end else if (state_q == ST_CALC && dcnt_q != DIV_END) begin
				dcnt_q <= dcnt_q + 1'b1;
			end

			if (state_q == ST_UPD) begin
				if (cand_yellow_q) begin
					yellow_max_q <= new_max;
					if (take) begin
						yellow_x_q <= cand_x_q[COORD_W-1:0];
						yellow_y_q <= cand_y_q;
					end
				end else begin
					red_max_q <= new_max;
					if (take) begin
						red_x_q <= cand_x_q;
						red_y_q <= cand_y_q;
					end
				end
			end

			if (out_load) begin
				out_valid_q  <= 1'b1;
				red_x_q      <= '0;
				red_y_q      <= '0;
				red_max_q    <= '0;
				yellow_x_q   <= '0;
				yellow_y_q   <= '0;
				yellow_max_q <= '0;
			end else if (target_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q <= tx;
			out_y_q <= ty;
		end
	end

	assign target_out.valid    = out_valid_q;
	assign target_out.target_x = out_x_q;
	assign target_out.target_y = out_y_q;

`ifndef SYNTH
	a_dist_only_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(d_new.busy || d_old.busy) |-> state_q == ST_CALC)
		else $error("distance unit busy outside calc");

	a_upd_after_all_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> (!d_new.busy && !d_old.busy && dcnt_q == DIV_END))
		else $error("update before divide/distance finished");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (red_max_q == '0 && yellow_max_q == '0 && out_valid_q))
		else $error("frame state not cleared after result");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result word raised outside fin");
`endif

endmodule
